### hdl/shiprrip_pkg.sv
// Shared types, constants and helpers for the SHiP/SRRIP replacement policy block.
// No dependencies; imported by the top level, the reuse table and the victim scan.
package shiprrip_pkg;

  localparam int DEF_NUM_SETS = 2048;
  localparam int DEF_NUM_WAYS = 16;

  localparam int SET_IN_W     = 11;
  localparam int WAY_IN_W     = 4;
  localparam int ADDR_W       = 64;
  localparam int PC_W         = 64;
  localparam int RRPV_W       = 2;
  localparam int SIG_W        = 6;
  localparam int SIG_COUNT    = 2 ** SIG_W;
  localparam int CNT_W        = 2;
  localparam int STRIDE_W     = 8;
  localparam int SCORE_W      = 2;
  localparam int THR_W        = 2;
  localparam int LINE_SHIFT   = 6;
  localparam int HASH_SHIFT_A = 6;
  localparam int HASH_SHIFT_B = 12;
  localparam int APB_AW       = 3;
  localparam int APB_DW       = 32;

  localparam logic [RRPV_W-1:0]  RRPV_FAR   = 2'd3;
  localparam logic [RRPV_W-1:0]  RRPV_LONG  = 2'd2;
  localparam logic [RRPV_W-1:0]  RRPV_NEAR  = 2'd0;
  localparam logic [CNT_W-1:0]   CNT_MAX    = 2'd3;
  localparam logic [CNT_W-1:0]   CNT_INIT   = 2'd1;
  localparam logic [SCORE_W-1:0] SCORE_MAX  = 2'd3;
  localparam logic [THR_W-1:0]   THR_RESET  = 2'd2;

  typedef enum logic {
    OP_SELECT = 1'b0,
    OP_UPDATE = 1'b1
  } op_t;

  typedef enum logic {
    REG_STREAM_THR = 1'b0,
    REG_REUSE_THR  = 1'b1
  } reg_idx_t;

  typedef logic [SIG_W-1:0] sig_t;

  typedef struct packed {
    logic             rd_en;
    sig_t             rd_addr;
    logic             wr_en;
    sig_t             wr_addr;
    logic [CNT_W-1:0] wr_data;
  } ctr_req_t;

  function automatic sig_t pc_hash(input logic [PC_W-1:0] pc);
    logic [PC_W-1:0] mix;
    mix = pc ^ (pc >> HASH_SHIFT_A) ^ (pc >> HASH_SHIFT_B);
    return mix[SIG_W-1:0];
  endfunction

endpackage

### hdl/ship_rrip_stream_bypass_policy.sv
// Top level of the SHiP/SRRIP replacement policy with per-set stream bypass.
// Depends on shiprrip_pkg, shiprrip_row_ram, shiprrip_reuse_table, shiprrip_victim_scan.
//
//   channel  | handshake                 | payload
//   ---------+---------------------------+------------------------------------------
//   input    | in_valid / in_ready       | operation, set, way, addr, pc, hit, evict
//   result   | out_valid / out_ready     | victim_way, set_streaming
//   config   | psel/penable/pwrite/pready| paddr, pwdata, prdata (thresholds)
//
// One item at a time. Select: read, execute, then the one-way-per-cycle victim scan;
// update: read and execute, then a counter read and write if an evicted signature
// counter is lowered. A set index reduction comes first when NUM_SETS is below 2048.
// After reset a clearing pass initializes the set rows.
// A result enters the output register once it is free; then the next item is taken.
module ship_rrip_stream_bypass_policy import shiprrip_pkg::*; #(
  parameter int NUM_SETS = DEF_NUM_SETS,
  parameter int NUM_WAYS = DEF_NUM_WAYS
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_operation,
  input  logic [SET_IN_W-1:0] in_set_index,
  input  logic [WAY_IN_W-1:0] in_way_index,
  input  logic [ADDR_W-1:0]   in_phys_addr,
  input  logic [PC_W-1:0]     in_prog_counter,
  input  logic                in_is_hit,
  input  logic                in_victim_valid,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [WAY_IN_W-1:0] out_victim_way,
  output logic                out_set_streaming,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [APB_AW-1:0]   paddr,
  input  logic [APB_DW-1:0]   pwdata,
  output logic [APB_DW-1:0]   prdata,
  output logic                pready
);

  localparam int SET_AW    = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
  localparam int WAY_W     = $clog2(NUM_WAYS);
  localparam int MOD_STEPS = (NUM_SETS >= 2 ** SET_IN_W) ? 0 : SET_IN_W;
  localparam int STEP_W    = $clog2(SET_IN_W);
  localparam int DIV_W     = 2 * SET_IN_W;
  localparam int WOK_W     = WAY_IN_W + 2;
  localparam int RRIP_BITS = NUM_WAYS * RRPV_W;
  localparam int SIG_BITS  = NUM_WAYS * SIG_W;
  localparam int SIG_LO    = RRIP_BITS;
  localparam int ADDR_LO   = SIG_LO + SIG_BITS;
  localparam int STRIDE_LO = ADDR_LO + ADDR_W;
  localparam int SCORE_LO  = STRIDE_LO + STRIDE_W;
  localparam int ROW_W     = SCORE_LO + SCORE_W;

  typedef enum logic [8:0] {
    S_CLEAR  = 9'b000000001,
    S_IDLE   = 9'b000000010,
    S_MOD    = 9'b000000100,
    S_READ   = 9'b000001000,
    S_EXEC   = 9'b000010000,
    S_SCAN   = 9'b000100000,
    S_DEC_RD = 9'b001000000,
    S_DEC_WR = 9'b010000000,
    S_DONE   = 9'b100000000
  } state_t;

  state_t              state_r, state_nxt;
  logic [SET_AW-1:0]   clr_r;
  logic [SET_IN_W-1:0] rem_r;
  logic [STEP_W-1:0]   step_r;
  op_t                 op_r;
  logic [WAY_IN_W-1:0] way_r;
  logic [ADDR_W-1:0]   addr_r;
  sig_t                sig_r;
  logic                hit_r;
  logic                evict_r;
  sig_t                old_sig_r;
  logic [WAY_IN_W-1:0] res_vic_r;
  logic                res_stream_r;
  logic                out_valid_r;
  logic [WAY_IN_W-1:0] out_vic_r;
  logic                out_stream_r;
  logic [THR_W-1:0]    stream_thr_r;
  logic [THR_W-1:0]    reuse_thr_r;

  logic [SET_AW-1:0]                set_a;
  logic                             row_rd_en;
  logic                             row_wr_en;
  logic [SET_AW-1:0]                row_wr_addr;
  logic [ROW_W-1:0]                 row_wdata;
  logic [ROW_W-1:0]                 row_q;
  logic [NUM_WAYS-1:0][RRPV_W-1:0]  rrip_q, rrip_upd, rrip_age;
  logic [NUM_WAYS-1:0][SIG_W-1:0]   sig_q, sig_upd;
  logic [ADDR_W-1:0]                prev_addr_q;
  logic [STRIDE_W-1:0]              prev_stride_q;
  logic [SCORE_W-1:0]               score_q;
  logic [STRIDE_W-1:0]              stride;
  logic                             stride_run;
  logic [STRIDE_W-1:0]              stride_upd;
  logic [SCORE_W-1:0]               score_upd;
  logic                             streaming_upd;
  logic [WAY_W-1:0]                 way_i;
  logic                             way_ok;
  logic [DIV_W-1:0]                 div_step;
  ctr_req_t                         ctr_req;
  logic [CNT_W-1:0]                 cnt_q;
  logic                             scan_start;
  logic                             scan_done;
  logic [RRPV_W-1:0]                scan_top;
  logic [WAY_W-1:0]                 scan_vic;
  logic                             out_load;
  logic                             cfg_wr;

  // ---------------- storage ----------------
  shiprrip_row_ram #(
    .WIDTH(ROW_W),
    .DEPTH(NUM_SETS)
  ) u_row_ram (
    .clk    (clk),
    .rd_en  (row_rd_en),
    .rd_addr(set_a),
    .rd_data(row_q),
    .wr_en  (row_wr_en),
    .wr_addr(row_wr_addr),
    .wr_data(row_wdata)
  );

  shiprrip_reuse_table u_reuse (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (ctr_req),
    .rd_data(cnt_q)
  );

  shiprrip_victim_scan #(
    .NUM_WAYS(NUM_WAYS)
  ) u_scan (
    .clk   (clk),
    .rst_n (rst_n),
    .start (scan_start),
    .rrip  (rrip_q),
    .done  (scan_done),
    .top   (scan_top),
    .victim(scan_vic)
  );

  // ---------------- row fields ----------------
  assign rrip_q        = row_q[0 +: RRIP_BITS];
  assign sig_q         = row_q[SIG_LO +: SIG_BITS];
  assign prev_addr_q   = row_q[ADDR_LO +: ADDR_W];
  assign prev_stride_q = row_q[STRIDE_LO +: STRIDE_W];
  assign score_q       = row_q[SCORE_LO +: SCORE_W];

  assign set_a    = SET_AW'(rem_r);
  assign way_i    = WAY_W'(way_r);
  assign way_ok   = WOK_W'(way_r) < WOK_W'(NUM_WAYS);
  assign div_step = DIV_W'(NUM_SETS) << step_r;

  // ---------------- stride detector and line update ----------------
  always_comb begin
    stride = '0;
    if (prev_addr_q != '0) begin
      stride = addr_r[LINE_SHIFT +: STRIDE_W] - prev_addr_q[LINE_SHIFT +: STRIDE_W];
    end
    stride_run = (stride != '0) && (stride == prev_stride_q);
    if (stride_run) begin
      stride_upd = prev_stride_q;
      score_upd  = (score_q == SCORE_MAX) ? score_q : score_q + SCORE_W'(1);
    end else begin
      stride_upd = stride;
      score_upd  = '0;
    end
    streaming_upd = score_upd >= stream_thr_r;

    rrip_upd = rrip_q;
    sig_upd  = sig_q;
    if (way_ok) begin
      if (hit_r) begin
        rrip_upd[way_i] = RRPV_NEAR;
      end else if (streaming_upd) begin
        rrip_upd[way_i] = RRPV_FAR;
      end else begin
        sig_upd[way_i]  = sig_r;
        rrip_upd[way_i] = (cnt_q >= reuse_thr_r) ? RRPV_NEAR : RRPV_LONG;
      end
    end
  end

  always_comb begin
    for (int w = 0; w < NUM_WAYS; w++) begin
      rrip_age[w] = rrip_q[w] + (RRPV_FAR - scan_top);
    end
  end

  // ---------------- sequencer ----------------
  assign in_ready   = (state_r == S_IDLE);
  assign out_load   = (state_r == S_DONE) && (!out_valid_r || out_ready);
  assign scan_start = (state_r == S_EXEC) && (op_r == OP_SELECT);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR:  if (clr_r == SET_AW'(NUM_SETS - 1)) state_nxt = S_IDLE;
      S_IDLE:   if (in_valid) state_nxt = (MOD_STEPS == 0) ? S_READ : S_MOD;
      S_MOD:    if (step_r == '0) state_nxt = S_READ;
      S_READ:   state_nxt = S_EXEC;
      S_EXEC: begin
        if (op_r == OP_SELECT) begin
          state_nxt = S_SCAN;
        end else if (!hit_r && way_ok && evict_r) begin
          state_nxt = S_DEC_RD;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_SCAN:   if (scan_done) state_nxt = S_DONE;
      S_DEC_RD: state_nxt = S_DEC_WR;
      S_DEC_WR: state_nxt = S_DONE;
      S_DONE:   if (out_load) state_nxt = S_IDLE;
      default:  state_nxt = S_CLEAR;
    endcase
  end

  always_comb begin
    row_rd_en   = (state_r == S_READ);
    row_wr_en   = 1'b0;
    row_wr_addr = set_a;
    row_wdata   = {score_upd, stride_upd, addr_r, sig_upd, rrip_upd};
    ctr_req     = '0;
    unique case (state_r)
      S_CLEAR: begin
        row_wr_en   = 1'b1;
        row_wr_addr = clr_r;
        row_wdata   = '0;
        row_wdata[0 +: RRIP_BITS] = {NUM_WAYS{RRPV_FAR}};
      end
      S_READ: begin
        ctr_req.rd_en   = 1'b1;
        ctr_req.rd_addr = sig_r;
      end
      S_EXEC: begin
        if (op_r == OP_UPDATE) begin
          row_wr_en = 1'b1;
          if (hit_r) begin
            ctr_req.wr_en   = 1'b1;
            ctr_req.wr_addr = sig_r;
            ctr_req.wr_data = (cnt_q == CNT_MAX) ? cnt_q : cnt_q + CNT_W'(1);
          end
        end
      end
      S_SCAN: begin
        row_wr_en = scan_done;
        row_wdata = {score_q, prev_stride_q, prev_addr_q, sig_q, rrip_age};
      end
      S_DEC_RD: begin
        ctr_req.rd_en   = 1'b1;
        ctr_req.rd_addr = old_sig_r;
      end
      S_DEC_WR: begin
        ctr_req.wr_en   = 1'b1;
        ctr_req.wr_addr = old_sig_r;
        ctr_req.wr_data = (cnt_q == '0) ? cnt_q : cnt_q - CNT_W'(1);
      end
      default: begin
      end
    endcase
  end

  // ---------------- control registers ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLEAR) begin
        clr_r <= clr_r + SET_AW'(1);
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // ---------------- item and result payload ----------------
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op_r    <= op_t'(in_operation);
      rem_r   <= in_set_index;
      step_r  <= STEP_W'(MOD_STEPS - 1);
      way_r   <= in_way_index;
      addr_r  <= in_phys_addr;
      sig_r   <= pc_hash(in_prog_counter);
      hit_r   <= in_is_hit;
      evict_r <= in_victim_valid;
    end
    if (state_r == S_MOD) begin
      // restoring reduction of the set index, one shifted modulus per cycle
      if (DIV_W'(rem_r) >= div_step) begin
        rem_r <= rem_r - SET_IN_W'(div_step);
      end
      step_r <= step_r - STEP_W'(1);
    end
    if (state_r == S_EXEC) begin
      old_sig_r <= sig_q[way_i];
      if (op_r == OP_UPDATE) begin
        res_vic_r    <= '0;
        res_stream_r <= streaming_upd;
      end
    end
    if ((state_r == S_SCAN) && scan_done) begin
      res_vic_r    <= WAY_IN_W'(scan_vic);
      res_stream_r <= score_q >= stream_thr_r;
    end
    if (out_load) begin
      out_vic_r    <= res_vic_r;
      out_stream_r <= res_stream_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_victim_way    = out_vic_r;
  assign out_set_streaming = out_stream_r;

  // ---------------- configuration port ----------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stream_thr_r <= THR_RESET;
      reuse_thr_r  <= THR_RESET;
    end else if (cfg_wr) begin
      unique case (reg_idx_t'(paddr[2]))
        REG_STREAM_THR: stream_thr_r <= pwdata[THR_W-1:0];
        REG_REUSE_THR:  reuse_thr_r  <= pwdata[THR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_idx_t'(paddr[2]))
      REG_STREAM_THR: prdata = APB_DW'(stream_thr_r);
      REG_REUSE_THR:  prdata = APB_DW'(reuse_thr_r);
      default:        prdata = '0;
    endcase
  end

endmodule

### hdl/shiprrip_row_ram.sv
// Per-set row memory: one write port, one read port with registered data.
// Standalone; width and depth come from the instantiating level.
module shiprrip_row_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### hdl/shiprrip_reuse_table.sv
// Signature reuse counters: 64 x 2-bit memory, registered read.
// Per-entry valid bits make unwritten counters read as their reset value.
// Depends on shiprrip_pkg.
module shiprrip_reuse_table import shiprrip_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  ctr_req_t         req,
  output logic [CNT_W-1:0] rd_data
);

  logic [CNT_W-1:0]     mem [SIG_COUNT];
  logic [SIG_COUNT-1:0] vld_r;
  logic [CNT_W-1:0]     rd_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (req.wr_en) begin
      vld_r[req.wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data_r <= vld_r[req.rd_addr] ? mem[req.rd_addr] : CNT_INIT;
    end
  end

  assign rd_data = rd_data_r;

endmodule

### hdl/shiprrip_victim_scan.sv
// Iterative victim search: one way per cycle through a shared compare,
// tracking the highest RRPV and the first way that holds it. Depends on shiprrip_pkg.
module shiprrip_victim_scan import shiprrip_pkg::*; #(
  parameter int NUM_WAYS = DEF_NUM_WAYS,
  localparam int WAY_W = $clog2(NUM_WAYS)
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [NUM_WAYS-1:0][RRPV_W-1:0] rrip,
  output logic                           done,
  output logic [RRPV_W-1:0]              top,
  output logic [WAY_W-1:0]               victim
);

  localparam logic [WAY_W-1:0] LAST = WAY_W'(NUM_WAYS - 1);

  logic              busy_r;
  logic              done_r;
  logic [WAY_W-1:0]  idx_r;
  logic [RRPV_W-1:0] max_r;
  logic [WAY_W-1:0]  vic_r;
  logic              at_last;

  assign at_last = busy_r && (idx_r == LAST);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= at_last;
      if (start) begin
        busy_r <= 1'b1;
      end else if (at_last) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      idx_r <= '0;
      max_r <= '0;
      vic_r <= '0;
    end else if (busy_r) begin
      idx_r <= idx_r + WAY_W'(1);
      if (rrip[idx_r] > max_r) begin
        max_r <= rrip[idx_r];
        vic_r <= idx_r;
      end
    end
  end

  assign done   = done_r;
  assign top    = max_r;
  assign victim = vic_r;

endmodule

### hdl/shiprrip_checker.sv
// Port-level checks for the replacement policy top level, bound to it below.
// Sees only the top level's ports.
module shiprrip_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [3:0] out_victim_way,
  input logic       out_set_streaming
);

  // held result must not change while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_victim_way)
                                && $stable(out_set_streaming))
    else $error("result changed while stalled");

  // one item in flight
  a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("item taken while busy");

  // row clearing pass runs before the first item
  a_clear_pass: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(rst_n) |-> !in_ready)
    else $error("ready during clearing pass");

  // a result needs at least the read and execute steps
  a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !$rose(out_valid))
    else $error("result appeared too early");

endmodule

bind ship_rrip_stream_bypass_policy shiprrip_checker u_shiprrip_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_victim_way   (out_victim_way),
  .out_set_streaming(out_set_streaming)
);
